FILE: design/sprite_scanline_slot_allocator_unit_defines.svh
// Assertion macros for the sprite scanline slot allocator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SPRITE_SCANLINE_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define SPRITE_SCANLINE_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted (active low).
`define SSA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssa check failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted (active low).
`define SSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssa check failed: next-cycle implication");
`else
`define SSA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/ssa_pkg.sv
// Shared types and constants for the sprite scanline slot allocator.
// No dependencies; imported by sprite_scanline_slot_allocator_unit.
package ssa_pkg;

    localparam int SCREEN_ROWS      = 25;
    localparam int SCREEN_COLS      = 32;
    localparam int TILE_PIXEL_WIDTH = 6;
    localparam int SPRITE_COUNT     = 32;

    localparam int KIND_W  = 2;
    localparam int IDX_W   = 5;
    localparam int COORD_W = 8;
    localparam int SLOT_W  = 8;
    localparam int CFG_W   = 8;

    localparam int ROW_PIXELS = 8;
    localparam int ROW_W      = 3;
    localparam int SLOTS      = 4;
    localparam int LINES      = SCREEN_ROWS * ROW_PIXELS;
    localparam int LINE_W     = $clog2(LINES);
    localparam int BOTTOM     = (SCREEN_ROWS + 1) * ROW_PIXELS;
    localparam int RIGHT      = (SCREEN_COLS + 1) * TILE_PIXEL_WIDTH;

    // Wide enough for y + row and for the screen edge constants.
    localparam int POS_W = 10;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    localparam int OV_PRIO_BIT = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPRITE,
        ST_READ
    } t_state;

    typedef logic [SLOTS*SLOT_W-1:0] t_line_row;

endpackage

FILE: design/sprite_scanline_slot_allocator_unit.sv
// Sprite scanline slot allocator: top level with the line table and its sequencer.
// Depends on ssa_pkg and sprite_scanline_slot_allocator_unit_defines.svh.
//
// The block keeps four sprite-row slots for each display line in a line table
// (one 32-bit memory row per line, a flip-flop valid bit per line). A clear beat
// drops every valid bit at once, so an invalid line reads as four empty
// slots and no clearing pass is needed, also not after reset. A sprite beat
// walks the sprite's eight rows through one shared add/compare unit: each cycle
// it forms y+row, checks it against the clip line and the bottom edge, reads the
// target line, and in the following cycle writes the row code into the first
// empty slot (reads and writes overlap, each row hits a different line). A sprite
// beat holds the input until its eight rows are walked and the last row is
// written; an ignored sprite, a clear and an unused kind keep the block idle. A
// read beat holds the input through the memory read and the load of the output
// register, which waits while that register stays full; the read data is held
// meanwhile. The result sits in an output register, so sprite and clear beats
// are taken while a read result still waits downstream.
// Configuration writes are always ready and are registered; a write during a sprite walk changes its clip line.
`include "sprite_scanline_slot_allocator_unit_defines.svh"

module sprite_scanline_slot_allocator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ssa_pkg::KIND_W-1:0]    i_kind,
    input  logic [ssa_pkg::IDX_W-1:0]     i_sprite_index,
    input  logic [ssa_pkg::COORD_W-1:0]   i_sprite_x,
    input  logic [ssa_pkg::COORD_W-1:0]   i_sprite_y,
    input  logic [ssa_pkg::COORD_W-1:0]   i_read_line,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ssa_pkg::SLOT_W-1:0]    o_slot_a,
    output logic [ssa_pkg::SLOT_W-1:0]    o_slot_b,
    output logic [ssa_pkg::SLOT_W-1:0]    o_slot_c,
    output logic [ssa_pkg::SLOT_W-1:0]    o_slot_d,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ssa_pkg::CFG_W-1:0]     i_cfg_data
);
    import ssa_pkg::*;

    // Line table: one row of four slots per display line.
    t_line_row mem [LINES];

    // Control state
    t_state               r_state, n_state;
    logic [ROW_W:0]       r_row;
    logic [LINES-1:0]     r_valid;
    logic                 r_wr_pend;
    logic                 r_out_valid;
    logic [CFG_W-1:0]     r_ov;

    // Payload registers
    logic [IDX_W-1:0]     r_idx;
    logic [COORD_W-1:0]   r_y;
    logic [LINE_W-1:0]    r_wr_line;
    logic [SLOT_W-1:0]    r_wr_code;
    logic                 r_rd_oob;
    t_line_row            r_rdata;
    logic                 r_rvalid;
    logic [SLOT_W-1:0]    r_slot_a, r_slot_b, r_slot_c, r_slot_d;

    // Combinational
    logic                 in_acc;
    logic                 out_take;
    logic                 load_out;
    logic                 spr_ok;
    logic                 spr_start;
    logic                 row_walk;
    logic                 rd_line_ok;
    logic [POS_W-1:0]     clip;
    logic [POS_W-1:0]     py;
    logic                 row_hit;
    logic [LINE_W-1:0]    row_line;
    logic [LINE_W-1:0]    rd_addr;
    t_line_row            cur_slots;
    t_line_row            wr_data;
    logic                 wr_found;
    logic                 wr_en;
    logic                 clear_all;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign clear_all   = in_acc && (i_kind == KIND_CLEAR);
    assign spr_start   = in_acc && (i_kind == KIND_SPRITE) && spr_ok;
    assign row_walk    = (r_state == ST_SPRITE) && !r_row[ROW_W];

    // Clip line: (tile rows + 1) * 8 with overlay priority and a nonzero count, else 8.
    always_comb begin
        if (r_ov[OV_PRIO_BIT] && (r_ov[3:0] != 4'd0)) begin
            clip = POS_W'({1'b0, r_ov[3:0]} + 5'd1) << 3;
        end else begin
            clip = POS_W'(ROW_PIXELS);
        end
    end

    // Visibility and index range of an incoming sprite, and the range of a read line.
    always_comb begin
        spr_ok = (i_sprite_index != '0)
              && (POS_W'(i_sprite_index) < POS_W'(SPRITE_COUNT))
              && (i_sprite_y != '0) && (POS_W'(i_sprite_y) < POS_W'(BOTTOM))
              && (i_sprite_x != '0) && (POS_W'(i_sprite_x) < POS_W'(RIGHT));
        rd_line_ok = POS_W'(i_read_line) < POS_W'(LINES);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (spr_start) begin
                    n_state = ST_SPRITE;
                end else if (in_acc && (i_kind == KIND_READ)) begin
                    n_state = ST_READ;
                end
            end
            ST_SPRITE: begin
                if (r_row[ROW_W]) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: shared row unit, read address, write stage.
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        load_out   = (r_state == ST_READ) && (!r_out_valid || !i_out_stall);

        // shared add/compare unit: pixel line of the current row
        py       = POS_W'(r_y) + POS_W'(r_row[ROW_W-1:0]);
        row_hit  = row_walk && (py >= clip) && (py < POS_W'(BOTTOM));
        row_line = LINE_W'(py - POS_W'(ROW_PIXELS));

        case (r_state)
            ST_IDLE:   rd_addr = rd_line_ok ? i_read_line[LINE_W-1:0] : '0;
            ST_SPRITE: rd_addr = row_hit ? row_line : '0;
            default:   rd_addr = '0;
        endcase

        // place code into the first empty slot of the line just read
        cur_slots = r_rvalid ? r_rdata : '0;
        wr_data   = cur_slots;
        wr_found  = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            if (!wr_found && (cur_slots[s*SLOT_W +: SLOT_W] == '0)) begin
                wr_data[s*SLOT_W +: SLOT_W] = r_wr_code;
                wr_found = 1'b1;
            end
        end
        wr_en = r_wr_pend && wr_found;
    end

    // Line table; hold the read data while a read result waits
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wr_line] <= wr_data;
        end
        if (r_state != ST_READ) begin
            r_rdata  <= mem[rd_addr];
            r_rvalid <= r_valid[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row       <= '0;
            r_valid     <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_ov        <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                r_ov <= i_cfg_data;
            end

            // drop every line at once on a clear beat
            if (clear_all) begin
                r_valid <= '0;
            end else if (wr_en) begin
                r_valid[r_wr_line] <= 1'b1;
            end

            // advance the row walk; the write stage follows in the next cycle
            if (r_state == ST_SPRITE) begin
                r_row     <= r_row + 1'b1;
                r_wr_pend <= row_hit;
            end else begin
                r_row     <= '0;
                r_wr_pend <= 1'b0;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_idx    <= i_sprite_index;
            r_y      <= i_sprite_y;
            r_rd_oob <= !rd_line_ok;
        end
        if (r_state == ST_SPRITE) begin
            r_wr_line <= row_line;
            r_wr_code <= {r_row[ROW_W-1:0], r_idx};
        end
        if (load_out) begin
            r_slot_a <= r_rd_oob ? '0 : cur_slots[0*SLOT_W +: SLOT_W];
            r_slot_b <= r_rd_oob ? '0 : cur_slots[1*SLOT_W +: SLOT_W];
            r_slot_c <= r_rd_oob ? '0 : cur_slots[2*SLOT_W +: SLOT_W];
            r_slot_d <= r_rd_oob ? '0 : cur_slots[3*SLOT_W +: SLOT_W];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_slot_a    = r_slot_a;
    assign o_slot_b    = r_slot_b;
    assign o_slot_c    = r_slot_c;
    assign o_slot_d    = r_slot_d;

    // Checks
    `SSA_ASSERT_SAME(a_write_in_walk, i_clk, i_rst_n, wr_en, r_state == ST_SPRITE)
    `SSA_ASSERT_NEXT(a_sprite_starts, i_clk, i_rst_n, spr_start, r_state == ST_SPRITE && r_row == '0)
    `SSA_ASSERT_NEXT(a_walk_continues, i_clk, i_rst_n, row_walk, r_state == ST_SPRITE)
    `SSA_ASSERT_NEXT(a_clear_drops, i_clk, i_rst_n, clear_all, r_valid == '0)
    `SSA_ASSERT_NEXT(a_read_loads, i_clk, i_rst_n, load_out, r_out_valid && (r_state == ST_IDLE))

endmodule
